// File: design/serial_command_line_decoder_assert.svh
// Assertion macros for the checker file of the command line decoder
`ifndef SERIAL_COMMAND_LINE_DECODER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_DECODER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define SCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command line decoder check failed");

// Next-cycle implication, held off during reset
`define SCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command line decoder check failed");

`endif

// File: design/scd_pkg.sv
// Package of the command line decoder: types, string constants and parser step
`default_nettype none

package scd_pkg;

    localparam int LINE_BYTES_DEF = 256;
    localparam int NAME_LIMIT_DEF = 32;
    localparam int NLEN_W         = 6;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    localparam logic [103:0] STR_CMD     = "CMD:";
    localparam logic [103:0] STR_BTN     = "BTN:";
    localparam logic [103:0] STR_PITCH   = "OFFSET:PITCH:";
    localparam logic [103:0] STR_ROLL    = "OFFSET:ROLL:";
    localparam logic [103:0] STR_MODE    = {"OFFSET", "_MODE"};
    localparam logic [103:0] STR_EXIT    = {"OFFSET", "_EXIT"};
    localparam logic [103:0] STR_KEY4    = "key4";
    localparam logic [63:0]  STR_PRESSED = ":PRESSED";

    typedef enum logic [2:0] {
        KIND_UNRECOG = 3'd0,
        KIND_BUTTON  = 3'd1,
        KIND_PITCH   = 3'd2,
        KIND_ROLL    = 3'd3,
        KIND_MODE    = 3'd4,
        KIND_EXIT    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIG,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        neg;
        logic [15:0] mag;
    } parse_t;

    // Summary of the line collected so far
    typedef struct packed {
        logic               cmd;
        logic               pitch;
        logic               roll;
        logic               mode;
        logic               exitc;
        logic               btn;
        logic               key4;
        logic signed [15:0] pitch_val;
        logic signed [15:0] roll_val;
        logic [NLEN_W-1:0]  nlen;
    } line_sum_t;

    // Line store control from the sequencer to the matcher
    typedef struct packed {
        logic store;
        logic clr;
    } mctl_t;

    localparam parse_t PARSE_INIT = '{phase: PH_SKIP, neg: 1'b0, mag: 16'd0};

    // Character i of a string of n characters
    function automatic logic [7:0] str_char(logic [103:0] s, int n, int i);
        logic [7:0] r;
        r = 8'd0;
        for (int k = 0; k < 13; k++)
        begin
            if (k == n - 1 - i)
                r = s[8*k +: 8];
        end
        return r;
    endfunction

    // Advance the integer parser by one character
    function automatic parse_t parse_step(parse_t s, logic [7:0] c);
        parse_t      r;
        logic        dig;
        logic        ws;
        logic [19:0] acc;
        r   = s;
        dig = (c >= 8'h30) && (c <= 8'h39);
        ws  = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
        acc = 20'(s.mag) * 20'd10 + 20'(c - 8'h30);
        case (s.phase)
            PH_SKIP:
            begin
                if (ws)
                    r.phase = PH_SKIP;
                else if ((c == 8'h2B) || (c == 8'h2D))
                begin
                    r.neg   = (c == 8'h2D);
                    r.phase = PH_DIG;
                end
                else if (dig)
                begin
                    r.mag   = (acc > 20'd32768) ? 16'd32768 : acc[15:0];
                    r.phase = PH_DIG;
                end
                else
                    r.phase = PH_DONE;
            end
            PH_DIG:
            begin
                if (dig)
                    r.mag = (acc > 20'd32768) ? 16'd32768 : acc[15:0];
                else
                    r.phase = PH_DONE;
            end
            default: r = s;
        endcase
        return r;
    endfunction

    // Signed, saturated value of a parser state
    function automatic logic signed [15:0] parse_val(parse_t s);
        logic [16:0] wide;
        if (s.neg)
        begin
            wide = 17'd0 - {1'b0, s.mag};
            return signed'(wide[15:0]);
        end
        if (s.mag > 16'd32767)
            return 16'sd32767;
        return signed'(s.mag);
    endfunction

endpackage

`default_nettype wire

// File: design/scd_in_if.sv
// Input channel of the command line decoder: one received byte per item
`default_nettype none

interface scd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: design/scd_out_if.sv
// Result channel of the command line decoder
`default_nettype none

interface scd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  name_char;
    logic        last;
    logic [15:0] pitch_offset_now;
    logic [15:0] roll_offset_now;
    logic        exit_requested;

    modport source (output valid, output kind, output name_char, output last,
                    output pitch_offset_now, output roll_offset_now,
                    output exit_requested, input ready);
    modport sink (input valid, input kind, input name_char, input last,
                  input pitch_offset_now, input roll_offset_now,
                  input exit_requested, output ready);
endinterface

`default_nettype wire

// File: design/scd_match.sv
// Byte-by-byte line matcher: prefixes, commands, integer parsers, marker search
`default_nettype none

module scd_match #(
    parameter int LINE_BYTES = scd_pkg::LINE_BYTES_DEF,
    parameter int NAME_LIMIT = scd_pkg::NAME_LIMIT_DEF,
    localparam int AW = $clog2(LINE_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scd_pkg::mctl_t    ctl,
    input  wire logic [7:0]        rx_byte,
    output scd_pkg::line_sum_t     sum
);

    logic [AW-1:0]    len_reg;
    logic             zero_seen_reg;
    logic             cmd_ok_reg, btn_ok_reg, pitch_ok_reg, roll_ok_reg;
    logic             mode_ok_reg, exit_ok_reg, key4_ok_reg, found_reg;
    logic [AW-1:0]    mark_reg;
    logic [63:0]      win_reg;
    scd_pkg::parse_t  pp_reg, rp_reg;

    logic [31:0]      p;
    logic             eff;
    logic [63:0]      win_next;
    logic             hit;

    assign p        = 32'(len_reg);
    assign eff      = ctl.store && !zero_seen_reg && (rx_byte != 8'd0);
    assign win_next = {win_reg[55:0], rx_byte};
    assign hit      = (win_next == scd_pkg::STR_PRESSED) && (p >= 32'd10) && !found_reg;

    // Advance match state on each counted byte; clear at line end or on overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            zero_seen_reg <= 1'b0;
            cmd_ok_reg    <= 1'b1;
            btn_ok_reg    <= 1'b1;
            pitch_ok_reg  <= 1'b1;
            roll_ok_reg   <= 1'b1;
            mode_ok_reg   <= 1'b1;
            exit_ok_reg   <= 1'b1;
            key4_ok_reg   <= 1'b1;
            found_reg     <= 1'b0;
            mark_reg      <= '0;
            win_reg       <= '0;
            pp_reg        <= scd_pkg::PARSE_INIT;
            rp_reg        <= scd_pkg::PARSE_INIT;
        end
        else if (ctl.clr)
        begin
            len_reg       <= '0;
            zero_seen_reg <= 1'b0;
            cmd_ok_reg    <= 1'b1;
            btn_ok_reg    <= 1'b1;
            pitch_ok_reg  <= 1'b1;
            roll_ok_reg   <= 1'b1;
            mode_ok_reg   <= 1'b1;
            exit_ok_reg   <= 1'b1;
            key4_ok_reg   <= 1'b1;
            found_reg     <= 1'b0;
            mark_reg      <= '0;
            win_reg       <= '0;
            pp_reg        <= scd_pkg::PARSE_INIT;
            rp_reg        <= scd_pkg::PARSE_INIT;
        end
        else if (ctl.store && !zero_seen_reg && (rx_byte == 8'd0))
        begin
            zero_seen_reg <= 1'b1;
        end
        else if (eff)
        begin
            len_reg <= len_reg + AW'(1);
            win_reg <= win_next;
            if ((p < 32'd4) && (rx_byte != scd_pkg::str_char(scd_pkg::STR_CMD, 4, int'(p))))
                cmd_ok_reg <= 1'b0;
            if ((p < 32'd4) && (rx_byte != scd_pkg::str_char(scd_pkg::STR_BTN, 4, int'(p))))
                btn_ok_reg <= 1'b0;
            if ((p >= 32'd4) && (p < 32'd17)
                && (rx_byte != scd_pkg::str_char(scd_pkg::STR_PITCH, 13, int'(p) - 4)))
                pitch_ok_reg <= 1'b0;
            if ((p >= 32'd4) && (p < 32'd16)
                && (rx_byte != scd_pkg::str_char(scd_pkg::STR_ROLL, 12, int'(p) - 4)))
                roll_ok_reg <= 1'b0;
            if ((p >= 32'd4) && (p < 32'd15)
                && (rx_byte != scd_pkg::str_char(scd_pkg::STR_MODE, 11, int'(p) - 4)))
                mode_ok_reg <= 1'b0;
            if ((p >= 32'd4) && (p < 32'd15)
                && (rx_byte != scd_pkg::str_char(scd_pkg::STR_EXIT, 11, int'(p) - 4)))
                exit_ok_reg <= 1'b0;
            if ((p >= 32'd4) && (p < 32'd8)
                && (rx_byte != scd_pkg::str_char(scd_pkg::STR_KEY4, 4, int'(p) - 4)))
                key4_ok_reg <= 1'b0;
            if (p >= 32'd17)
                pp_reg <= scd_pkg::parse_step(pp_reg, rx_byte);
            if (p >= 32'd16)
                rp_reg <= scd_pkg::parse_step(rp_reg, rx_byte);
            // Record the first marker, counted from its first character
            if (hit)
            begin
                found_reg <= 1'b1;
                mark_reg  <= AW'(p - 32'd7);
            end
        end
    end

    // Summarise the line for the sequencer
    logic [31:0] len32, mark32;
    assign len32  = 32'(len_reg);
    assign mark32 = 32'(mark_reg);

    always_comb
    begin
        sum.cmd       = cmd_ok_reg && (len32 >= 32'd4);
        sum.pitch     = sum.cmd && pitch_ok_reg && (len32 >= 32'd17);
        sum.roll      = sum.cmd && roll_ok_reg && (len32 >= 32'd16);
        sum.mode      = sum.cmd && mode_ok_reg && (len32 == 32'd15);
        sum.exitc     = sum.cmd && exit_ok_reg && (len32 == 32'd15);
        sum.btn       = btn_ok_reg && (len32 >= 32'd4) && found_reg && (mark32 > 32'd4)
                        && ((mark32 - 32'd4) < 32'(NAME_LIMIT));
        sum.key4      = key4_ok_reg && (mark32 == 32'd8);
        sum.pitch_val = scd_pkg::parse_val(pp_reg);
        sum.roll_val  = scd_pkg::parse_val(rp_reg);
        sum.nlen      = scd_pkg::NLEN_W'(mark32 - 32'd4);
    end

endmodule

`default_nettype wire

// File: design/scd_seq.sv
// Sequencer: line store, stored offsets and result emission over the store read port
`default_nettype none

module scd_seq #(
    parameter int LINE_BYTES = scd_pkg::LINE_BYTES_DEF,
    localparam int AW = $clog2(LINE_BYTES)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [7:0]              rx_byte,
    output logic                         in_ready,
    input  wire scd_pkg::line_sum_t      sum,
    output scd_pkg::mctl_t               ctl,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output scd_pkg::kind_t               kind,
    output logic [7:0]                   name_char,
    output logic                         last,
    output logic signed [15:0]           pitch_offset_now,
    output logic signed [15:0]           roll_offset_now,
    output logic                         exit_requested
);

    scd_pkg::state_t             state_reg, state_next;
    logic [AW-1:0]               wp_reg, addr_reg;
    logic [scd_pkg::NLEN_W-1:0]  cnt_reg;
    scd_pkg::kind_t              kind_reg;
    logic [7:0]                  char_reg, rd_data_reg;
    logic                        last_reg;
    logic signed [15:0]          pitch_reg, roll_reg;
    logic                        exit_reg;
    logic [7:0]                  mem [LINE_BYTES];

    logic                        in_fire, is_eol, decode, button;
    scd_pkg::kind_t              dec_kind;

    assign in_fire = in_valid && in_ready;
    assign is_eol  = (rx_byte == scd_pkg::CH_LF) || (rx_byte == scd_pkg::CH_CR);
    assign decode  = in_fire && is_eol && (wp_reg != '0);
    assign button  = !sum.cmd && sum.btn;
    assign ctl.store = in_fire && !is_eol && (32'(wp_reg) < LINE_BYTES - 1);
    assign ctl.clr   = in_fire && !ctl.store;

    // Pick the kind of a single-result line
    always_comb
    begin
        if (sum.pitch)
            dec_kind = scd_pkg::KIND_PITCH;
        else if (sum.roll)
            dec_kind = scd_pkg::KIND_ROLL;
        else if (sum.mode)
            dec_kind = scd_pkg::KIND_MODE;
        else if (sum.exitc)
            dec_kind = scd_pkg::KIND_EXIT;
        else
            dec_kind = scd_pkg::KIND_UNRECOG;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scd_pkg::S_IDLE:
            begin
                if (decode)
                    state_next = button ? scd_pkg::S_FETCH : scd_pkg::S_EMIT;
            end
            scd_pkg::S_FETCH: state_next = scd_pkg::S_LOAD;
            scd_pkg::S_LOAD:  state_next = scd_pkg::S_EMIT;
            scd_pkg::S_EMIT:
            begin
                if (out_ready)
                    state_next = (cnt_reg > scd_pkg::NLEN_W'(1)) ? scd_pkg::S_FETCH
                                                                 : scd_pkg::S_IDLE;
            end
            default: state_next = scd_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == scd_pkg::S_IDLE);
        out_valid = (state_reg == scd_pkg::S_EMIT);
    end

    assign kind             = kind_reg;
    assign name_char        = char_reg;
    assign last             = last_reg;
    assign pitch_offset_now = pitch_reg;
    assign roll_offset_now  = roll_reg;
    assign exit_requested   = exit_reg;

    // Control state: sequencer, write position, offsets, exit flag, name count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scd_pkg::S_IDLE;
            wp_reg    <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
            exit_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.store)
                wp_reg <= wp_reg + AW'(1);
            else if (ctl.clr)
                wp_reg <= '0;
            if (decode)
            begin
                if (sum.pitch)
                    pitch_reg <= sum.pitch_val;
                else if (sum.roll)
                    roll_reg <= sum.roll_val;
                if (button && sum.key4)
                    exit_reg <= 1'b1;
                // A single-result line counts as one item
                cnt_reg <= button ? sum.nlen : scd_pkg::NLEN_W'(1);
            end
            else if ((state_reg == scd_pkg::S_EMIT) && out_ready)
                cnt_reg <= cnt_reg - scd_pkg::NLEN_W'(1);
        end
    end

    // Result payload and name read address
    always_ff @(posedge clk)
    begin
        if (decode)
        begin
            kind_reg <= dec_kind;
            char_reg <= 8'd0;
            last_reg <= 1'b1;
            addr_reg <= AW'(4);
        end
        else if (state_reg == scd_pkg::S_LOAD)
        begin
            kind_reg <= scd_pkg::KIND_BUTTON;
            char_reg <= rd_data_reg;
            last_reg <= (cnt_reg == scd_pkg::NLEN_W'(1));
        end
        else if ((state_reg == scd_pkg::S_EMIT) && out_ready)
            addr_reg <= addr_reg + AW'(1);
    end

    // Line store: write on stored bytes, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.store)
            mem[wp_reg] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[addr_reg];
    end

endmodule

`default_nettype wire

// File: design/serial_command_line_decoder.sv
// Top level of the serial command line decoder
//
//   channel  | dir | payload                                        | handshake
//   rx       | in  | rx_byte                                        | valid/ready
//   res      | out | kind, name_char, last, pitch_offset_now,       | valid/ready
//            |     | roll_offset_now, exit_requested                |
//
// An ordinary byte is taken and ready stays high for the next.
// A non-empty line's end offers a single result the cycle after it is taken;
// button names come out one character at a time over the single registered read
// port of the line store (fetch, load, present). Ready returns once all are taken.
// Reset is asynchronous and needs no clearing pass; the line store is never cleared.
// While a result stalls, rx ready stays low.
`default_nettype none

module serial_command_line_decoder #(
    parameter int LINE_BYTES = scd_pkg::LINE_BYTES_DEF,
    parameter int NAME_LIMIT = scd_pkg::NAME_LIMIT_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    scd_in_if.sink     rx,
    scd_out_if.source  res
);

    scd_pkg::line_sum_t sum;
    scd_pkg::mctl_t     ctl;
    scd_pkg::kind_t     kind;
    logic signed [15:0] pitch_now, roll_now;

    scd_match #(
        .LINE_BYTES (LINE_BYTES),
        .NAME_LIMIT (NAME_LIMIT)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rx_byte (rx.rx_byte),
        .sum     (sum)
    );

    scd_seq #(
        .LINE_BYTES (LINE_BYTES)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (rx.valid),
        .rx_byte          (rx.rx_byte),
        .in_ready         (rx.ready),
        .sum              (sum),
        .ctl              (ctl),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .kind             (kind),
        .name_char        (res.name_char),
        .last             (res.last),
        .pitch_offset_now (pitch_now),
        .roll_offset_now  (roll_now),
        .exit_requested   (res.exit_requested)
    );

    assign res.kind             = 3'(kind);
    assign res.pitch_offset_now = 16'(pitch_now);
    assign res.roll_offset_now  = 16'(roll_now);

endmodule

`default_nettype wire

// File: design/scd_checker.sv
// Port-level checks of the command line decoder and their bind
`default_nettype none

`include "serial_command_line_decoder_assert.svh"

module scd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] kind,
    input wire logic [7:0] name_char,
    input wire logic       last,
    input wire logic       exit_requested
);

    // Never take a byte while a result is offered
    `SCD_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

    // Non-button results carry no name character
    `SCD_ASSERT_NOW(a_char_zero, out_valid && (kind != scd_pkg::KIND_BUTTON), name_char == 8'd0)

    // Exit request never falls once set
    `SCD_ASSERT_NEXT(a_exit_sticky, exit_requested, exit_requested)

    // A stalled result holds
    `SCD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(last))

endmodule

bind serial_command_line_decoder scd_checker u_scd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (rx.ready),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .kind           (res.kind),
    .name_char      (res.name_char),
    .last           (res.last),
    .exit_requested (res.exit_requested)
);

`default_nettype wire
